// ===== rtl/ntws_pkg.sv =====
// Shared types, operation and status codes, and default sizes for the node table search block
package ntws_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // map size that reset prepares
  localparam logic [5:0] RESET_MAP_SIZE = 6'd32;

  // width of the scaled-by-ten window arithmetic
  localparam int WW = 38;
  // width of the counters compared against DEPTH
  localparam int CW = 7;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_BOUNDS = 2'd2;
  localparam logic [1:0] OP_SEARCH = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NO_GOAL = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] node_weight;
    logic signed [31:0] position;
    logic [30:0]        step_size;
  } in_t;

  typedef struct packed {
    logic [5:0]  match_index;
    logic        match_valid;
    logic [6:0]  match_count;
    logic [30:0] max_x;
    logic [30:0] max_y;
    logic [30:0] max_weight;
    logic [1:0]  status;
    logic        last;
  } out_t;

endpackage

// ===== rtl/ntws_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module ntws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/node_table_window_search.sv =====
// Node table with clear, add, bounds and window search, scanned slot by slot from RAM
//
// Usage: pulse start with an item on in_item while busy is low; the item is
// taken at that edge and busy rises on the next cycle. Results come out on
// out_item, one per cycle that out_strobe is high; the final result of an
// item has last set, and busy is already low in that cycle. The receiver
// cannot stall: every strobed result must be taken as it appears.
// map_size is written through cfg_valid/cfg_ready/cfg_data, by the user only
// while idle, which the block does not enforce; cfg_ready is always high.
// Work per item, from acceptance to the last result:
//   clear:  one RAM write per slot for min(map_size, DEPTH) slots, then the end mark.
//   add, bounds: a scan that stops at slot k or at the last slot, paced by
//   the one read per cycle of the node RAMs.
//   search: the same scan, then one cycle per slot up to the last hit while
//   the hits are sent.
// Reset: map_size returns to 32 and the weight table reads as min(DEPTH, 32)
// free slots followed by the end mark; per-slot valid bits stand in for the reset
// value, so no clearing pass runs and the block is ready right after reset.
module node_table_window_search
  import ntws_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_t        in_item,
  output logic       out_strobe,
  output out_t       out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data
);

  localparam int XAW = $clog2(DEPTH);
  localparam int WAW = $clog2(DEPTH + 1);
  localparam int RST_N = (DEPTH < 32) ? DEPTH : 32;

  localparam logic signed [31:0] MarkFree = -(32'sd3 <<< FRAC_BITS);
  localparam logic signed [31:0] MarkEnd  = -(32'sd4 <<< FRAC_BITS);
  localparam logic signed [31:0] MarkGoal = -(32'sd2 <<< FRAC_BITS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLEAR = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [WAW-1:0]        idx_r, idx_nxt;
  logic [WAW-1:0]        chk_r, chk_nxt;
  logic                  dv_r, dv_nxt;
  logic [5:0]            clr_n_r, clr_n_nxt;
  logic signed [31:0]    ax_r, ax_nxt, ay_r, ay_nxt, aw_r, aw_nxt;
  logic signed [WW-1:0]  pos10_r, pos10_nxt, s11_r, s11_nxt, hi10_r, hi10_nxt;
  logic [DEPTH-1:0]      hit_r, hit_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt, em_r, em_nxt;
  logic signed [31:0]    mx_r, mx_nxt, my_r, my_nxt, mw_r, mw_nxt;
  logic [DEPTH:0]        wvld_r, wvld_nxt;
  logic                  rvld_r;
  logic [5:0]            map_size_r, map_size_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  out_t                  out_item_r, out_item_nxt;

  logic                  w_we, xy_we;
  logic [WAW-1:0]        w_waddr;
  logic [31:0]           w_wdata, w_rdata;
  logic [XAW-1:0]        xy_waddr, xy_raddr;
  logic [63:0]           xy_wdata, xy_rdata;

  logic signed [31:0]    w_eff, x_rd, y_rd;
  logic signed [WW-1:0]  p38, s38, x38, x10;
  logic                  issue, at_end, in_win;
  out_t                  res;

  ntws_ram #(.WIDTH(32), .DEPTH(DEPTH + 1)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (idx_r),
    .rdata (w_rdata)
  );

  ntws_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_xy_ram (
    .clk   (clk),
    .we    (xy_we),
    .waddr (xy_waddr),
    .wdata (xy_wdata),
    .raddr (xy_raddr),
    .rdata (xy_rdata)
  );

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  assign issue    = (CW'(idx_r) < CW'(DEPTH));
  assign xy_raddr = issue ? idx_r[XAW-1:0] : '0;

  // A slot never written reads as its reset mark.
  assign w_eff = rvld_r ? w_rdata
               : ((CW'(chk_r) < CW'(RST_N)) ? MarkFree : MarkEnd);
  assign x_rd  = xy_rdata[63:32];
  assign y_rd  = xy_rdata[31:0];

  assign p38    = WW'(in_item.position);
  assign s38    = WW'(in_item.step_size);
  assign x38    = WW'(x_rd);
  assign x10    = (x38 <<< 3) + (x38 <<< 1);
  assign in_win = (x10 > pos10_r) && (x10 < hi10_r);
  assign at_end = (CW'(chk_r) == CW'(DEPTH - 1));

  assign map_size_nxt = cfg_valid ? cfg_data : map_size_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    chk_nxt        = idx_r;
    dv_nxt         = 1'b0;
    clr_n_nxt      = clr_n_r;
    ax_nxt         = ax_r;
    ay_nxt         = ay_r;
    aw_nxt         = aw_r;
    pos10_nxt      = pos10_r;
    s11_nxt        = s11_r;
    hi10_nxt       = hi10_r;
    hit_nxt        = hit_r;
    cnt_nxt        = cnt_r;
    em_nxt         = em_r;
    mx_nxt         = mx_r;
    my_nxt         = my_r;
    mw_nxt         = mw_r;
    wvld_nxt       = wvld_r;
    out_strobe_nxt = 1'b0;
    res            = '0;
    w_we           = 1'b0;
    w_waddr        = idx_r;
    w_wdata        = MarkFree;
    xy_we          = 1'b0;
    xy_waddr       = idx_r[XAW-1:0];
    xy_wdata       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_item.operation;
          idx_nxt   = '0;
          clr_n_nxt = (CW'(map_size_r) > CW'(DEPTH)) ? 6'(DEPTH) : map_size_r;
          ax_nxt    = in_item.x_coord;
          ay_nxt    = in_item.y_coord;
          aw_nxt    = in_item.node_weight;
          pos10_nxt = (p38 <<< 3) + (p38 <<< 1);
          s11_nxt   = (s38 <<< 3) + (s38 <<< 1) + s38;
          hit_nxt   = '0;
          cnt_nxt   = '0;
          em_nxt    = '0;
          mx_nxt    = '0;
          my_nxt    = '0;
          mw_nxt    = '0;
          state_nxt = (in_item.operation == OP_CLEAR) ? S_CLEAR : S_SCAN;
        end
      end

      S_CLEAR: begin
        w_we = 1'b1;
        if (CW'(idx_r) < CW'(clr_n_r)) begin
          w_wdata = MarkFree;
          xy_we   = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else begin
          w_wdata        = MarkEnd;
          res.last       = 1'b1;
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_SCAN: begin
        // read one slot ahead of the one being examined
        dv_nxt   = issue;
        idx_nxt  = idx_r + WAW'(issue);
        hi10_nxt = pos10_r + s11_r;
        if (dv_r) begin
          unique case (op_r)
            OP_ADD: begin
              if (w_eff == MarkFree) begin
                w_we           = 1'b1;
                w_waddr        = chk_r;
                w_wdata        = aw_r;
                xy_we          = 1'b1;
                xy_waddr       = chk_r[XAW-1:0];
                xy_wdata       = {ax_r, ay_r};
                res.last       = 1'b1;
                out_strobe_nxt = 1'b1;
                state_nxt      = S_IDLE;
              end else if (w_eff == MarkEnd || at_end) begin
                res.status     = ST_FULL;
                res.last       = 1'b1;
                out_strobe_nxt = 1'b1;
                state_nxt      = S_IDLE;
              end
            end
            OP_BOUNDS: begin
              if (w_eff == MarkFree || w_eff == MarkEnd) begin
                res.max_x      = mx_r[30:0];
                res.max_y      = my_r[30:0];
                res.max_weight = mw_r[30:0];
                res.last       = 1'b1;
                out_strobe_nxt = 1'b1;
                state_nxt      = S_IDLE;
              end else begin
                if (mx_r < x_rd) mx_nxt = x_rd;
                if (my_r < y_rd) my_nxt = y_rd;
                if (mw_r < w_eff) mw_nxt = w_eff;
                if (at_end) begin
                  res.max_x      = mx_nxt[30:0];
                  res.max_y      = my_nxt[30:0];
                  res.max_weight = mw_nxt[30:0];
                  res.last       = 1'b1;
                  out_strobe_nxt = 1'b1;
                  state_nxt      = S_IDLE;
                end
              end
            end
            default: begin
              if (w_eff == MarkGoal) begin
                if (cnt_r == '0) begin
                  res.last       = 1'b1;
                  out_strobe_nxt = 1'b1;
                  state_nxt      = S_IDLE;
                end else begin
                  idx_nxt   = '0;
                  state_nxt = S_EMIT;
                end
              end else if (w_eff == MarkEnd || at_end) begin
                res.status     = ST_NO_GOAL;
                res.last       = 1'b1;
                out_strobe_nxt = 1'b1;
                state_nxt      = S_IDLE;
              end else if (in_win) begin
                hit_nxt[chk_r[XAW-1:0]] = 1'b1;
                cnt_nxt                 = cnt_r + 1'b1;
              end
            end
          endcase
        end
      end

      S_EMIT: begin
        idx_nxt = idx_r + 1'b1;
        if (hit_r[idx_r[XAW-1:0]]) begin
          em_nxt          = em_r + 1'b1;
          res.match_index = 6'(idx_r);
          res.match_valid = 1'b1;
          out_strobe_nxt  = 1'b1;
          if (em_nxt == cnt_r) begin
            res.match_count = cnt_r;
            res.last        = 1'b1;
            state_nxt       = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (w_we) begin
      wvld_nxt[w_waddr] = 1'b1;
    end
    out_item_nxt = out_strobe_nxt ? res : out_item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dv_r         <= 1'b0;
      wvld_r       <= '0;
      map_size_r   <= RESET_MAP_SIZE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      dv_r         <= dv_nxt;
      wvld_r       <= wvld_nxt;
      map_size_r   <= map_size_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    chk_r      <= chk_nxt;
    clr_n_r    <= clr_n_nxt;
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    aw_r       <= aw_nxt;
    pos10_r    <= pos10_nxt;
    s11_r      <= s11_nxt;
    hi10_r     <= hi10_nxt;
    hit_r      <= hit_nxt;
    cnt_r      <= cnt_nxt;
    em_r       <= em_nxt;
    mx_r       <= mx_nxt;
    my_r       <= my_nxt;
    mw_r       <= mw_nxt;
    rvld_r     <= wvld_r[idx_r];
    out_item_r <= out_item_nxt;
  end

endmodule

// ===== rtl/ntws_checker.sv =====
// Port-level checks for the node table search block, bound to its top level
module ntws_checker
  import ntws_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input out_t out_item
);

  // an accepted transaction always occupies the block
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a transaction");

  // the block goes idle only together with the final result
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_strobe && out_item.last))
    else $error("busy dropped without a final result");

  // intermediate results are search hits sent while still busy
  a_mid_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.last) |-> (busy && out_item.match_valid))
    else $error("non-final result that is not a search hit");

  // every result stems from work in progress
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a transaction in progress");

  // an error status ends the transaction and carries no hit
  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status != ST_OK) |-> (out_item.last && !out_item.match_valid))
    else $error("error status on a non-final or hit result");

endmodule

bind node_table_window_search ntws_checker u_ntws_checker (.*);

// ===== bench/node_table_window_search_tb.sv =====
// Self-checking testbench for node_table_window_search: directed and random command streams
module node_table_window_search_tb;
  import ntws_pkg::*;

  localparam int ONE    = 1 << FRAC_BITS_DEF;
  localparam int W_FREE = -3 * ONE;
  localparam int W_END  = -4 * ONE;
  localparam int W_GOAL = -2 * ONE;
  localparam int Q_MAX  = 32'sh7fff_ffff;
  localparam int Q_MIN  = 32'sh8000_0000;
  localparam int DRAIN_CYCLES = 2 * DEPTH_DEF + 4;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_t        in_item = '0;
  logic       out_strobe;
  out_t       out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [5:0] cfg_data = '0;

  node_table_window_search dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_strobe(out_strobe),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  class search_scoreboard;
    logic signed [31:0] x_tab[DEPTH_DEF];
    logic signed [31:0] y_tab[DEPTH_DEF];
    logic signed [31:0] w_tab[DEPTH_DEF + 1];
    logic [5:0] map_size;
    out_t expected_results[$];
    int errors, commands, results, hits, full_adds, lost_goals;

    function new();
      map_size = RESET_MAP_SIZE;
      foreach (x_tab[k]) begin
        x_tab[k] = '0;
        y_tab[k] = '0;
      end
      foreach (w_tab[k]) w_tab[k] = W_END;
      clear_slots(RESET_MAP_SIZE);
    endfunction

    function void clear_slots(logic [5:0] size);
      int n;
      n = (size > DEPTH_DEF) ? DEPTH_DEF : size;
      for (int k = 0; k < n; k++) begin
        x_tab[k] = '0;
        y_tab[k] = '0;
        w_tab[k] = W_FREE;
      end
      w_tab[n] = W_END;
    endfunction

    function void set_map_size(logic [5:0] size);
      map_size = size;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_command(in_t c);
      out_t r;
      longint mx, my, mw, pos10, hi10, x10;
      int found[$];
      bit goal;
      int k;
      r = '0;
      r.last = 1'b1;
      commands++;
      case (c.operation)
        OP_CLEAR: clear_slots(map_size);
        OP_ADD: begin
          r.status = ST_FULL;
          for (k = 0; k < DEPTH_DEF; k++) begin
            if (w_tab[k] == W_FREE) begin
              w_tab[k] = c.node_weight;
              x_tab[k] = c.x_coord;
              y_tab[k] = c.y_coord;
              r.status = ST_OK;
              break;
            end
            if (w_tab[k] == W_END) break;
          end
        end
        OP_BOUNDS: begin
          mx = 0;
          my = 0;
          mw = 0;
          for (k = 0; k < DEPTH_DEF; k++) begin
            if (w_tab[k] == W_FREE || w_tab[k] == W_END) break;
            if (x_tab[k] > mx) mx = x_tab[k];
            if (y_tab[k] > my) my = y_tab[k];
            if (w_tab[k] > mw) mw = w_tab[k];
          end
          r.max_x = mx[30:0];
          r.max_y = my[30:0];
          r.max_weight = mw[30:0];
        end
        OP_SEARCH: begin
          // scale by ten so the 1.1 factor stays exact
          pos10 = longint'(c.position) * 10;
          hi10 = pos10 + longint'(c.step_size) * 11;
          goal = 1'b0;
          for (k = 0; k < DEPTH_DEF; k++) begin
            if (w_tab[k] == W_GOAL) begin
              goal = 1'b1;
              break;
            end
            if (w_tab[k] == W_END) break;
            x10 = longint'(x_tab[k]) * 10;
            if (x10 > pos10 && x10 < hi10) found.push_back(k);
          end
          if (!goal) begin
            r.status = ST_NO_GOAL;
          end else begin
            foreach (found[i]) begin
              r.match_index = 6'(found[i]);
              r.match_valid = 1'b1;
              r.last = (i == found.size() - 1);
              r.match_count = r.last ? 7'(found.size()) : 7'd0;
              if (!r.last) expected_results.push_back(r);
            end
          end
        end
      endcase
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        $error("result with no transaction waiting: %h", got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      results++;
      if (want.match_valid) hits++;
      if (want.status == ST_FULL) full_adds++;
      if (want.status == ST_NO_GOAL) lost_goals++;
      compare_field("match_index", 32'(want.match_index), 32'(got.match_index));
      compare_field("match_valid", 32'(want.match_valid), 32'(got.match_valid));
      compare_field("match_count", 32'(want.match_count), 32'(got.match_count));
      compare_field("max_x", 32'(want.max_x), 32'(got.max_x));
      compare_field("max_y", 32'(want.max_y), 32'(got.max_y));
      compare_field("max_weight", 32'(want.max_weight), 32'(got.max_weight));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  search_scoreboard sb = new();
  int map_now = int'(RESET_MAP_SIZE);
  int sent = 0;
  bit burst = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("[node_table_window_search] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_result(out_item);
      if (start && !busy) sb.note_command(in_item);
      if (cfg_valid && cfg_ready) sb.set_map_size(cfg_data);
    end
  end

  function automatic in_t pack_cmd(logic [1:0] op, int x = 0, int y = 0, int w = 0,
                                   int pos = 0, int step = 0);
    in_t c;
    c.operation   = op;
    c.x_coord     = x;
    c.y_coord     = y;
    c.node_weight = w;
    c.position    = pos;
    c.step_size   = step[30:0];
    return c;
  endfunction

  task automatic issue(input in_t c);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    // keep start high across back-to-back transactions
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= c;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_map_size(input logic [5:0] size);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    map_now = int'(size);
  endtask

  // clear, fill some or all of the table around one x base, then search near that base
  task automatic run_session(input bit dense);
    int slots, adds, goal_at, base, x, w, pos, step, pick;
    slots = (map_now > DEPTH_DEF) ? DEPTH_DEF : map_now;
    if (dense) adds = slots + 1;
    else if ($urandom_range(0, 5) == 0) adds = $urandom_range(0, slots + 1);
    else adds = $urandom_range(0, (slots < 6) ? slots + 1 : 6);
    goal_at = dense ? slots - 1 : $urandom_range(0, adds);
    base = (int'($urandom_range(0, 400)) - 200) * ONE;
    issue(pack_cmd(OP_CLEAR));
    for (int i = 0; i < adds; i++) begin
      x = base + int'($urandom_range(1, dense ? ONE - 1 : 8 * ONE));
      if (!dense && $urandom_range(0, 9) == 0) x = $urandom;
      pick = $urandom_range(0, 19);
      if (i == goal_at) w = W_GOAL;
      else if (dense || pick > 3) w = $urandom_range(0, 100 * ONE);
      else if (pick == 0) w = W_FREE;
      else if (pick == 1) w = W_END;
      else w = $urandom;
      issue(pack_cmd(OP_ADD, x, $urandom, w));
    end
    repeat ($urandom_range(1, 4)) begin
      pos = base + int'($urandom_range(0, 4 * ONE)) - ONE;
      step = $urandom_range(0, 6 * ONE);
      if (dense) begin
        pos = base;
        step = ONE;
      end else if ($urandom_range(0, 9) == 0) begin
        pos = $urandom;
        step = $urandom;
      end
      issue(pack_cmd(OP_SEARCH, 0, 0, 0, pos, step));
      if ($urandom_range(0, 2) == 0) issue(pack_cmd(OP_BOUNDS));
    end
    if ($urandom_range(0, 3) == 0)
      issue(pack_cmd(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                     $urandom, $urandom));
  endtask

  initial begin
    int random_from;
    logic [5:0] size;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // add and bounds straight out of reset, then a clear so every x is written
    issue(pack_cmd(OP_ADD, Q_MAX, Q_MIN, 3 * ONE / 2));
    issue(pack_cmd(OP_BOUNDS));
    issue(pack_cmd(OP_CLEAR));
    issue(pack_cmd(OP_SEARCH, 0, 0, 0, 0, ONE));
    issue(pack_cmd(OP_ADD, ONE, 2 * ONE, ONE));
    issue(pack_cmd(OP_ADD, 2 * ONE, -ONE, ONE / 2));
    issue(pack_cmd(OP_ADD, Q_MIN, Q_MAX, Q_MAX));
    issue(pack_cmd(OP_ADD, 5 * ONE, 0, W_GOAL));
    issue(pack_cmd(OP_ADD, 3 * ONE / 2, 0, Q_MIN));
    issue(pack_cmd(OP_SEARCH, 0, 0, 0, ONE / 2, ONE));
    issue(pack_cmd(OP_SEARCH, 0, 0, 0, 0, 2 * ONE));
    issue(pack_cmd(OP_SEARCH, 0, 0, 0, 10 * ONE, ONE));
    issue(pack_cmd(OP_SEARCH, 0, 0, 0, Q_MIN, Q_MAX));
    issue(pack_cmd(OP_SEARCH, 0, 0, 0, 0, 0));
    issue(pack_cmd(OP_BOUNDS));
    // marks written as weights: free leaves the slot open, end truncates the table
    issue(pack_cmd(OP_ADD, -ONE, -ONE, W_FREE));
    issue(pack_cmd(OP_ADD, 4 * ONE, ONE, W_END));
    issue(pack_cmd(OP_ADD, ONE, ONE, ONE));
    write_map_size(6'd1);
    issue(pack_cmd(OP_CLEAR));
    issue(pack_cmd(OP_ADD, ONE, ONE, W_GOAL));
    issue(pack_cmd(OP_ADD, ONE, ONE, ONE));
    issue(pack_cmd(OP_SEARCH, 0, 0, 0, 0, 4 * ONE));
    write_map_size(6'd0);
    issue(pack_cmd(OP_CLEAR));
    issue(pack_cmd(OP_ADD, ONE, ONE, ONE));
    issue(pack_cmd(OP_SEARCH, 0, 0, 0, 0, ONE));

    random_from = sent;
    // fill every slot with the goal last so each search returns a full list
    write_map_size(6'd63);
    run_session(1'b1);
    while (sent - random_from < 230) begin
      burst = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 7))
        0: begin
          case ($urandom_range(0, 5))
            0: size = 6'd0;
            1: size = 6'd1;
            2: size = 6'd63;
            3: size = RESET_MAP_SIZE;
            default: size = 6'($urandom_range(1, 63));
          endcase
          write_map_size(size);
        end
        1: settle();
        default: ;
      endcase
      run_session(1'b0);
    end
    burst = 1'b0;

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    $display("Run covered %0d transactions and %0d results, map sizes 0 through 63.",
             sb.commands, sb.results);
    $display("Window hits: %0d, full-table adds: %0d, searches without goal: %0d.",
             sb.hits, sb.full_adds, sb.lost_goals);
    if (sb.errors == 0) begin
      $display("[node_table_window_search] OK");
    end else begin
      $display("[node_table_window_search] ERROR");
    end
    $finish;
  end

endmodule
